// ----- rtl/aipm_pkg.sv -----
// Shared types, widths and register codes for the affine inverse pixel mapper.
package aipm_pkg;

    localparam int COORD_BITS = 12;
    localparam int MAT_BITS   = 16;
    localparam int DIM_BITS   = 13;
    localparam int ADDR_BITS  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = MAT_BITS + COORD_BITS + 1;
    localparam int SUM_W      = PROD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_M_ROW_ROW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_M_ROW_COL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M_COL_ROW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M_COL_COL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE   = 3'd7;

    localparam logic EDGE_CLAMP = 1'b0;
    localparam logic EDGE_FILL  = 1'b1;

    typedef struct packed {
        logic [MAT_BITS-1:0] m_row_row;
        logic [MAT_BITS-1:0] m_row_col;
        logic [MAT_BITS-1:0] m_col_row;
        logic [MAT_BITS-1:0] m_col_col;
        logic [DIM_BITS-1:0] src_height;
        logic [DIM_BITS-1:0] src_width;
        logic [DIM_BITS-1:0] line_stride;
        logic                edge_mode;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] dest_row;
        logic [COORD_BITS-1:0] dest_col;
    } t_dest_pix;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_row;
        logic [COORD_BITS-1:0] src_col;
        logic [ADDR_BITS-1:0]  src_addr;
        logic                  use_fill;
    } t_src_pix;

endpackage

// ----- rtl/affine_inverse_pixel_mapper.sv -----
// One destination pixel per clock; o_busy stays low, the pipeline never stalls.
// Stages: two product multipliers, sum, rounding, edge handling, stride multiply, address add.
// The receiver cannot stall; each result is presented for exactly one cycle.
// Reset (synchronous, active low) clears all valid bits and loads identity matrix,
// 512x512 image, stride 512 and clamp mode.
module affine_inverse_pixel_mapper #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  aipm_pkg::t_dest_pix                i_dest,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [aipm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aipm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    output aipm_pkg::t_src_pix                 o_src
);
    import aipm_pkg::*;

    localparam int RND_W = SUM_W - FRAC_BITS;
    localparam int LAT   = 6;

    t_cfg                    cfg;
    logic signed [RND_W-1:0] row_rnd, col_rnd;
    logic [2:0]              r_vld;

    assign o_busy = 1'b0;

    aipm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    aipm_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_row (
        .i_clk   (i_clk),
        .i_ma    (cfg.m_row_row),
        .i_mb    (cfg.m_row_col),
        .i_r     (i_dest.dest_row),
        .i_c     (i_dest.dest_col),
        .o_coord (row_rnd)
    );

    aipm_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_col (
        .i_clk   (i_clk),
        .i_ma    (cfg.m_col_row),
        .i_mb    (cfg.m_col_col),
        .i_r     (i_dest.dest_row),
        .i_c     (i_dest.dest_col),
        .o_coord (col_rnd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start && !o_busy};
        end
    end

    aipm_bound #(.RND_W(RND_W)) u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (r_vld[2]),
        .i_row   (row_rnd),
        .i_col   (col_rnd),
        .o_valid (o_valid),
        .o_src   (o_src)
    );

    a_result_has_transaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result strobe without a matching input transaction");

    a_fill_zeroes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_src.use_fill) |->
            (o_src.src_row == '0 && o_src.src_col == '0 && o_src.src_addr == '0))
        else $error("fill result carries nonzero coordinates or address");

    a_fill_only_in_fill_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_src.use_fill) |-> (cfg.edge_mode == EDGE_FILL))
        else $error("fill flag raised in clamp mode");

endmodule

// ----- rtl/aipm_cfg.sv -----
// Configuration register file written over the valid/ready config channel.
module aipm_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [aipm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aipm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output aipm_pkg::t_cfg                     o_cfg
);
    import aipm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_M_ROW_ROW:   n_cfg.m_row_row   = i_cfg_data[MAT_BITS-1:0];
                REG_M_ROW_COL:   n_cfg.m_row_col   = i_cfg_data[MAT_BITS-1:0];
                REG_M_COL_ROW:   n_cfg.m_col_row   = i_cfg_data[MAT_BITS-1:0];
                REG_M_COL_COL:   n_cfg.m_col_col   = i_cfg_data[MAT_BITS-1:0];
                REG_SRC_HEIGHT:  n_cfg.src_height  = i_cfg_data[DIM_BITS-1:0];
                REG_SRC_WIDTH:   n_cfg.src_width   = i_cfg_data[DIM_BITS-1:0];
                REG_LINE_STRIDE: n_cfg.line_stride = i_cfg_data[DIM_BITS-1:0];
                REG_EDGE_MODE:   n_cfg.edge_mode   = i_cfg_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m_row_row   <= MAT_BITS'(4096);
            r_cfg.m_row_col   <= '0;
            r_cfg.m_col_row   <= '0;
            r_cfg.m_col_col   <= MAT_BITS'(4096);
            r_cfg.src_height  <= DIM_BITS'(512);
            r_cfg.src_width   <= DIM_BITS'(512);
            r_cfg.line_stride <= DIM_BITS'(512);
            r_cfg.edge_mode   <= EDGE_CLAMP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/aipm_mac.sv -----
// Three-stage multiply, sum and round-half-away unit for one source coordinate.
module aipm_mac #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                           i_clk,
    input  logic [aipm_pkg::MAT_BITS-1:0]                  i_ma,
    input  logic [aipm_pkg::MAT_BITS-1:0]                  i_mb,
    input  logic [aipm_pkg::COORD_BITS-1:0]                i_r,
    input  logic [aipm_pkg::COORD_BITS-1:0]                i_c,
    output logic signed [aipm_pkg::SUM_W-FRAC_BITS-1:0]    o_coord
);
    import aipm_pkg::*;

    localparam int RND_W = SUM_W - FRAC_BITS;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_prod_a;
    logic signed [PROD_W-1:0] r_prod_b;
    logic signed [SUM_W-1:0]  r_sum;
    logic        [SUM_W-1:0]  sum_adj;
    logic signed [RND_W-1:0]  r_coord;

    // negative sums take half minus one, so the arithmetic shift rounds away from zero
    assign sum_adj = r_sum + HALF - SUM_W'(r_sum[SUM_W-1]);
    assign o_coord = r_coord;

    always_ff @(posedge i_clk) begin
        r_prod_a <= $signed(i_ma) * $signed({1'b0, i_r});
        r_prod_b <= $signed(i_mb) * $signed({1'b0, i_c});
        r_sum    <= SUM_W'(r_prod_a) + SUM_W'(r_prod_b);
        r_coord  <= sum_adj[SUM_W-1:FRAC_BITS];
    end

endmodule

// ----- rtl/aipm_bound.sv -----
// Edge handling (clamp or fill) and linear address stages.
module aipm_bound #(
    parameter int RND_W = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  aipm_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    input  logic signed [RND_W-1:0]      i_row,
    input  logic signed [RND_W-1:0]      i_col,
    output logic                         o_valid,
    output aipm_pkg::t_src_pix           o_src
);
    import aipm_pkg::*;

    localparam int CMP_W = RND_W - 1;
    localparam logic [DIM_BITS-1:0] DIM_CAP = DIM_BITS'(1) << COORD_BITS;

    logic [DIM_BITS-1:0]   h_eff, w_eff, h_last, w_last;
    logic                  row_neg, col_neg, row_hi, col_hi, oob;
    logic [COORD_BITS-1:0] n_row, n_col;
    logic                  n_fill;

    logic [COORD_BITS-1:0]          r_row, r_col, r_row_b, r_col_b;
    logic                           r_fill, r_fill_b;
    logic [COORD_BITS+DIM_BITS-1:0] r_prod;
    logic                           r_vld_a, r_vld_b, r_vld_c;
    t_src_pix                       r_src;

    always_comb begin
        h_eff = i_cfg.src_height;
        if (h_eff == '0) h_eff = DIM_BITS'(1);
        if (h_eff > DIM_CAP) h_eff = DIM_CAP;
        w_eff = i_cfg.src_width;
        if (w_eff == '0) w_eff = DIM_BITS'(1);
        if (w_eff > DIM_CAP) w_eff = DIM_CAP;
        h_last = h_eff - DIM_BITS'(1);
        w_last = w_eff - DIM_BITS'(1);

        row_neg = i_row[RND_W-1];
        col_neg = i_col[RND_W-1];
        row_hi  = !row_neg && (i_row[CMP_W-1:0] >= CMP_W'(h_eff));
        col_hi  = !col_neg && (i_col[CMP_W-1:0] >= CMP_W'(w_eff));
        oob     = row_neg || row_hi || col_neg || col_hi;

        n_row  = i_row[COORD_BITS-1:0];
        n_col  = i_col[COORD_BITS-1:0];
        n_fill = 1'b0;
        if (i_cfg.edge_mode == EDGE_FILL) begin
            if (oob) begin
                n_fill = 1'b1;
                n_row  = '0;
                n_col  = '0;
            end
        end else begin
            if (row_neg) n_row = '0;
            if (row_hi)  n_row = h_last[COORD_BITS-1:0];
            if (col_neg) n_col = '0;
            if (col_hi)  n_col = w_last[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_fill   <= n_fill;
        r_prod   <= r_row * i_cfg.line_stride;
        r_row_b  <= r_row;
        r_col_b  <= r_col;
        r_fill_b <= r_fill;
        r_src.src_row  <= r_row_b;
        r_src.src_col  <= r_col_b;
        r_src.src_addr <= r_prod[ADDR_BITS-1:0] + ADDR_BITS'(r_col_b);
        r_src.use_fill <= r_fill_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    assign o_valid = r_vld_c;
    assign o_src   = r_src;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the affine inverse pixel mapper: directed table, then random phases.
module tb_top;

    import aipm_pkg::*;

    localparam int FRAC     = 12;
    localparam int N_PHASES = 8;
    localparam int PHASE_N  = 55;
    localparam int WD_LIMIT = 2000;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_dest_pix             dest;
        bit                    has_want;
        t_src_pix              want;
    } t_stim_row;

    localparam t_dest_pix NO_PIX = '0;
    localparam t_src_pix  NO_SRC = '0;
    localparam t_src_pix  FILLED = '{12'd0, 12'd0, 24'd0, 1'b1};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_dest_pix             i_dest;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    t_src_pix              o_src;

    t_cfg     cfg_model;
    t_src_pix pending_src[$];
    int       err_cnt  = 0;
    int       idle_cnt = 0;

    t_stim_row dir_rows[] = '{
        '{1'b0, '0, '0, '{12'd0, 12'd0}, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b0}},
        '{1'b0, '0, '0, '{12'd4095, 12'd4095}, 1'b1, '{12'd511, 12'd511, 24'd262143, 1'b0}},
        '{1'b0, '0, '0, '{12'd100, 12'd37}, 1'b1, '{12'd100, 12'd37, 24'd51237, 1'b0}},
        '{1'b0, '0, '0, '{12'd0, 12'd4095}, 1'b1, '{12'd0, 12'd511, 24'd511, 1'b0}},
        '{1'b1, REG_EDGE_MODE, {15'd0, EDGE_FILL}, NO_PIX, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd511, 12'd511}, 1'b1, '{12'd511, 12'd511, 24'd262143, 1'b0}},
        '{1'b0, '0, '0, '{12'd512, 12'd0}, 1'b1, FILLED},
        '{1'b0, '0, '0, '{12'd0, 12'd512}, 1'b1, FILLED},
        // half scale on rows, minus half on columns: rounding of halves
        '{1'b1, REG_M_ROW_ROW, 16'h0800, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_COL_COL, 16'hF800, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_EDGE_MODE, {15'd0, EDGE_CLAMP}, NO_PIX, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd1, 12'd1}, 1'b1, '{12'd1, 12'd0, 24'd512, 1'b0}},
        '{1'b0, '0, '0, '{12'd3, 12'd0}, 1'b1, '{12'd2, 12'd0, 24'd1024, 1'b0}},
        '{1'b0, '0, '0, '{12'd4095, 12'd4095}, 1'b1, '{12'd511, 12'd0, 24'd261632, 1'b0}},
        '{1'b0, '0, '0, '{12'd1, 12'd3}, 1'b0, NO_SRC},
        '{1'b1, REG_EDGE_MODE, {15'd0, EDGE_FILL}, NO_PIX, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd1, 12'd1}, 1'b1, FILLED},
        '{1'b0, '0, '0, '{12'd2, 12'd0}, 1'b1, '{12'd1, 12'd0, 24'd512, 1'b0}},
        // matrix extremes, oversized height, zero width, max stride
        '{1'b1, REG_M_ROW_ROW, 16'h7FFF, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_ROW_COL, 16'h8000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_COL_ROW, 16'h8000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_COL_COL, 16'h7FFF, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_SRC_HEIGHT, 16'h1FFF, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_SRC_WIDTH, 16'h0000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_LINE_STRIDE, 16'h1FFF, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_EDGE_MODE, {15'd0, EDGE_CLAMP}, NO_PIX, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd4095, 12'd0}, 1'b1, '{12'd4095, 12'd0, 24'd16764929, 1'b0}},
        '{1'b0, '0, '0, '{12'd0, 12'd4095}, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b0}},
        '{1'b0, '0, '0, '{12'd4095, 12'd4095}, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd2048, 12'd1}, 1'b0, NO_SRC},
        // full 4096 image, width above the cap, stride 4
        '{1'b1, REG_SRC_HEIGHT, 16'h1000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_SRC_WIDTH, 16'hF001, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_LINE_STRIDE, 16'd4, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_ROW_ROW, 16'h1000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_ROW_COL, 16'h0000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_COL_ROW, 16'h0000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_COL_COL, 16'h1000, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_EDGE_MODE, {15'd0, EDGE_FILL}, NO_PIX, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd4095, 12'd4095}, 1'b1, '{12'd4095, 12'd4095, 24'd20475, 1'b0}},
        '{1'b0, '0, '0, '{12'd0, 12'd0}, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b0}},
        // zero stride, column = row + col
        '{1'b1, REG_LINE_STRIDE, 16'd0, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_M_COL_ROW, 16'h1000, NO_PIX, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd4095, 12'd1}, 1'b1, FILLED},
        '{1'b0, '0, '0, '{12'd100, 12'd200}, 1'b1, '{12'd100, 12'd300, 24'd300, 1'b0}},
        // single-pixel image
        '{1'b1, REG_SRC_HEIGHT, 16'd1, NO_PIX, 1'b0, NO_SRC},
        '{1'b1, REG_SRC_WIDTH, 16'd1, NO_PIX, 1'b0, NO_SRC},
        '{1'b0, '0, '0, '{12'd0, 12'd0}, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b0}},
        '{1'b0, '0, '0, '{12'd1, 12'd0}, 1'b1, FILLED}
    };

    affine_inverse_pixel_mapper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_dest      (i_dest),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_src       (o_src)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint round_q12(logic [MAT_BITS-1:0] ka, logic [MAT_BITS-1:0] kb,
                                         longint r, longint c);
        longint s;
        longint q;
        s = longint'($signed(ka)) * r + longint'($signed(kb)) * c;
        q = ((s < 0 ? -s : s) + (longint'(1) << (FRAC - 1))) >>> FRAC;
        return (s < 0) ? -q : q;
    endfunction

    function automatic longint dim_limit(logic [DIM_BITS-1:0] v);
        longint x;
        x = longint'(v);
        if (x == 0) x = 1;
        if (x > (1 << COORD_BITS)) x = 1 << COORD_BITS;
        return x;
    endfunction

    function automatic t_src_pix map_pixel(t_dest_pix d);
        longint   r, c, sr, sc, h, w;
        bit       fill;
        t_src_pix p;
        r    = longint'(d.dest_row);
        c    = longint'(d.dest_col);
        sr   = round_q12(cfg_model.m_row_row, cfg_model.m_row_col, r, c);
        sc   = round_q12(cfg_model.m_col_row, cfg_model.m_col_col, r, c);
        h    = dim_limit(cfg_model.src_height);
        w    = dim_limit(cfg_model.src_width);
        fill = 1'b0;
        if (cfg_model.edge_mode == EDGE_FILL) begin
            if (sr < 0 || sr >= h || sc < 0 || sc >= w) begin
                fill = 1'b1;
                sr   = 0;
                sc   = 0;
            end
        end else begin
            if (sr < 0) sr = 0;
            if (sr >= h) sr = h - 1;
            if (sc < 0) sc = 0;
            if (sc >= w) sc = w - 1;
        end
        p.src_row  = sr[COORD_BITS-1:0];
        p.src_col  = sc[COORD_BITS-1:0];
        p.src_addr = fill ? '0 : ADDR_BITS'(longint'(p.src_row) * longint'(cfg_model.line_stride)
                                            + longint'(p.src_col));
        p.use_fill = fill;
        return p;
    endfunction

    // register model and result checker
    always @(posedge i_clk) begin : mon
        t_src_pix want;
        if (!i_rst_n) begin
            cfg_model = '{16'h1000, 16'h0000, 16'h0000, 16'h1000, 13'd512, 13'd512, 13'd512,
                          EDGE_CLAMP};
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_M_ROW_ROW:   cfg_model.m_row_row   = i_cfg_data;
                    REG_M_ROW_COL:   cfg_model.m_row_col   = i_cfg_data;
                    REG_M_COL_ROW:   cfg_model.m_col_row   = i_cfg_data;
                    REG_M_COL_COL:   cfg_model.m_col_col   = i_cfg_data;
                    REG_SRC_HEIGHT:  cfg_model.src_height  = i_cfg_data[DIM_BITS-1:0];
                    REG_SRC_WIDTH:   cfg_model.src_width   = i_cfg_data[DIM_BITS-1:0];
                    REG_LINE_STRIDE: cfg_model.line_stride = i_cfg_data[DIM_BITS-1:0];
                    REG_EDGE_MODE:   cfg_model.edge_mode   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (pending_src.size() == 0) begin
                    $error("result with no pending transaction");
                    err_cnt++;
                end else begin
                    want = pending_src.pop_front();
                    if (o_src.src_row !== want.src_row) begin
                        $error("src_row: expected %0d, got %0d", want.src_row, o_src.src_row);
                        err_cnt++;
                    end
                    if (o_src.src_col !== want.src_col) begin
                        $error("src_col: expected %0d, got %0d", want.src_col, o_src.src_col);
                        err_cnt++;
                    end
                    if (o_src.src_addr !== want.src_addr) begin
                        $error("src_addr: expected %0d, got %0d", want.src_addr, o_src.src_addr);
                        err_cnt++;
                    end
                    if (o_src.use_fill !== want.use_fill) begin
                        $error("use_fill: expected %0d, got %0d", want.use_fill, o_src.use_fill);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WD_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_pix(t_dest_pix d, bit typed, t_src_pix want);
        bit ok;
        i_start <= 1'b1;
        i_dest  <= d;
        do begin
            @(negedge i_clk);
            ok = !o_busy;
            @(posedge i_clk);
        end while (!ok);
        pending_src.push_back(typed ? want : map_pixel(d));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    task automatic drain();
        while (pending_src.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 16384)) - 16'd8192;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd4096;
            3: return 16'($urandom);
            default: return 16'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_stride();
        case ($urandom_range(0, 9))
            0: return 16'd4;
            1: return 16'd4096;
            2: return 16'd0;
            3: return 16'd8191;
            default: return 16'($urandom_range(4, 4096));
        endcase
    endfunction

    function automatic t_dest_pix pick_dest();
        t_dest_pix d;
        if ($urandom_range(0, 1)) begin
            d = 24'($urandom);
        end else begin
            d.dest_row = 12'($urandom_range(0, 600));
            d.dest_col = 12'($urandom_range(0, 600));
        end
        return d;
    endfunction

    initial begin
        bit prev_cfg;
        int burst_left;
        int gap;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_dest      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                if (!prev_cfg) begin
                    i_start <= 1'b0;
                    drain();
                end
                write_reg(dir_rows[n].idx, dir_rows[n].data);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                send_pix(dir_rows[n].dest, dir_rows[n].has_want, dir_rows[n].want);
                prev_cfg = 1'b0;
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            i_start <= 1'b0;
            drain();
            write_reg(REG_M_ROW_ROW, pick_coef());
            write_reg(REG_M_ROW_COL, pick_coef());
            write_reg(REG_M_COL_ROW, pick_coef());
            write_reg(REG_M_COL_COL, pick_coef());
            write_reg(REG_SRC_HEIGHT, pick_dim());
            write_reg(REG_SRC_WIDTH, pick_dim());
            write_reg(REG_LINE_STRIDE, pick_stride());
            write_reg(REG_EDGE_MODE, {15'd0, (ph % 2 == 1) ? EDGE_FILL : EDGE_CLAMP});
            i_cfg_valid <= 1'b0;
            burst_left = $urandom_range(1, 16);
            for (int k = 0; k < PHASE_N; k++) begin
                send_pix(pick_dest(), 1'b0, NO_SRC);
                if (ph == 2 && k == PHASE_N / 2) begin
                    // hold off until the pipeline is empty
                    i_start <= 1'b0;
                    drain();
                    continue;
                end
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap        = $urandom_range(0, 6);
                    if (gap != 0) begin
                        i_start <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end

        i_start <= 1'b0;
        drain();
        repeat (10) @(posedge i_clk);
        if (pending_src.size() != 0) begin
            $error("%0d transactions never produced a result", pending_src.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- affine_inverse_pixel_mapper.f -----
rtl/aipm_pkg.sv
rtl/aipm_cfg.sv
rtl/aipm_mac.sv
rtl/aipm_bound.sv
rtl/affine_inverse_pixel_mapper.sv
sim/tb_top.sv
